// ----- rtl/stt_pkg.sv -----
package stt_pkg;

   // Token kinds as they appear on the result channel.
   localparam logic [4:0] KIND_ILLEGAL = 5'd0;
   localparam logic [4:0] KIND_EOF     = 5'd1;
   localparam logic [4:0] KIND_IDENT   = 5'd2;
   localparam logic [4:0] KIND_INT     = 5'd3;
   localparam logic [4:0] KIND_ASSIGN  = 5'd4;
   localparam logic [4:0] KIND_PLUS    = 5'd5;
   localparam logic [4:0] KIND_MINUS   = 5'd6;
   localparam logic [4:0] KIND_STAR    = 5'd7;
   localparam logic [4:0] KIND_SLASH   = 5'd8;
   localparam logic [4:0] KIND_BANG    = 5'd9;
   localparam logic [4:0] KIND_LT      = 5'd10;
   localparam logic [4:0] KIND_GT      = 5'd11;
   localparam logic [4:0] KIND_COMMA   = 5'd12;
   localparam logic [4:0] KIND_SEMI    = 5'd13;
   localparam logic [4:0] KIND_LPAREN  = 5'd14;
   localparam logic [4:0] KIND_RPAREN  = 5'd15;
   localparam logic [4:0] KIND_LBRACE  = 5'd16;
   localparam logic [4:0] KIND_RBRACE  = 5'd17;
   localparam logic [4:0] KIND_LET     = 5'd18;
   localparam logic [4:0] KIND_FN      = 5'd19;

   // Scanner mode: what kind of token is pending.
   typedef enum logic [1:0] {
      MODE_IDLE  = 2'd0,
      MODE_IDENT = 2'd1,
      MODE_INT   = 2'd2
   } mode_type;

   // How much of a keyword the pending identifier has spelled so far.
   typedef enum logic [2:0] {
      KP_NONE = 3'd0,
      KP_L    = 3'd1,
      KP_LE   = 3'd2,
      KP_LET  = 3'd3,
      KP_F    = 3'd4,
      KP_FN   = 3'd5
   } kp_type;

   // One result item.
   typedef struct packed {
      logic [4:0]  token_kind;
      logic [15:0] start_offset;
      logic [15:0] token_length;
      logic [7:0]  char_value;
      logic        last_of_run;
   } result_item_type;

   localparam int unsigned MAX_RESULTS = 3;

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) || c == 8'h5f;
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic logic is_blank(input logic [7:0] c);
      return c == 8'h20 || c == 8'h09 || c == 8'h0d || c == 8'h0a;
   endfunction

   // Kind of a single-character token; anything unlisted is illegal.
   function automatic logic [4:0] op_kind(input logic [7:0] c);
      logic [4:0] k;
      case (c)
         8'h3d: k = KIND_ASSIGN;
         8'h2b: k = KIND_PLUS;
         8'h2d: k = KIND_MINUS;
         8'h2a: k = KIND_STAR;
         8'h2f: k = KIND_SLASH;
         8'h21: k = KIND_BANG;
         8'h3c: k = KIND_LT;
         8'h3e: k = KIND_GT;
         8'h2c: k = KIND_COMMA;
         8'h3b: k = KIND_SEMI;
         8'h28: k = KIND_LPAREN;
         8'h29: k = KIND_RPAREN;
         8'h7b: k = KIND_LBRACE;
         8'h7d: k = KIND_RBRACE;
         default: k = KIND_ILLEGAL;
      endcase
      return k;
   endfunction

   // Keyword tracking for a letter that continues an identifier.
   function automatic kp_type kp_advance(input kp_type kp, input logic [7:0] c);
      kp_type r;
      if (kp == KP_L && c == 8'h65) begin
         r = KP_LE;
      end else if (kp == KP_LE && c == 8'h74) begin
         r = KP_LET;
      end else if (kp == KP_F && c == 8'h6e) begin
         r = KP_FN;
      end else begin
         r = KP_NONE;
      end
      return r;
   endfunction

   // Keyword tracking for the first letter of an identifier.
   function automatic kp_type kp_first(input logic [7:0] c);
      kp_type r;
      if (c == 8'h6c) begin
         r = KP_L;
      end else if (c == 8'h66) begin
         r = KP_F;
      end else begin
         r = KP_NONE;
      end
      return r;
   endfunction

   // Kind of the pending token when it is flushed.
   function automatic logic [4:0] flush_kind(input mode_type m, input kp_type kp);
      logic [4:0] k;
      if (m == MODE_INT) begin
         k = KIND_INT;
      end else if (kp == KP_LET) begin
         k = KIND_LET;
      end else if (kp == KP_FN) begin
         k = KIND_FN;
      end else begin
         k = KIND_IDENT;
      end
      return k;
   endfunction

endpackage

// ----- rtl/stt_req_if.sv -----
interface stt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_text;

   modport source (output valid, output in_byte, output end_of_text, input ready);
   modport sink (input valid, input in_byte, input end_of_text, output ready);
endinterface

// ----- rtl/stt_rsp_if.sv -----
interface stt_rsp_if;
   logic        valid;
   logic        ready;
   logic [4:0]  token_kind;
   logic [15:0] start_offset;
   logic [15:0] token_length;
   logic [7:0]  char_value;
   logic        last_of_run;

   modport source (output valid, output token_kind, output start_offset,
                   output token_length, output char_value, output last_of_run,
                   input ready);
   modport sink (input valid, input token_kind, input start_offset,
                 input token_length, input char_value, input last_of_run,
                 output ready);
endinterface

// ----- rtl/source_text_tokenizer_top.sv -----
// Channel   Direction  Payload                                              Results
// req_bus   in         in_byte, end_of_text                                 one byte per transfer
// rsp_bus   out        token_kind, start_offset, token_length,              0 to 3 per byte
//                      char_value, last_of_run
//
// A byte is scanned in the cycle of its transfer and its results are captured in a result
// group at that edge; they pass through the output register one per cycle while rsp_bus is
// not stalled, and the first one is offered on rsp_bus once it is in the output register.
// Bytes with at most one result stream at one byte per cycle while rsp_bus is not stalled; a
// byte with more results holds the input while the three-entry result group drains into out_ff.
// Reset is synchronous: offset zero, no pending token, no results held, input not ready.
// A stalled output keeps its result; bytes are taken while it waits until one of them has results.
module source_text_tokenizer_top
   import stt_pkg::*;
#(
   parameter int unsigned OFFSET_BITS = 16
) (
   input  logic      clock,
   input  logic      reset,
   stt_req_if.sink   req_bus,
   stt_rsp_if.source rsp_bus
);

   // Scanner state.
   mode_type               mode_ff, mode_in;
   kp_type                 kp_ff, kp_in;
   logic [OFFSET_BITS-1:0] start_ff, start_in;
   logic [OFFSET_BITS-1:0] offset_ff, offset_in;

   // Results of the last scanned byte, drained one per cycle while the output is free or taken.
   result_item_type grp_ff [MAX_RESULTS];
   logic [1:0]      grp_cnt_ff;
   logic [1:0]      grp_idx_ff;

   // Output register.
   logic            out_valid_ff;
   result_item_type out_ff;

   // Scan logic signals.
   result_item_type        res_c [MAX_RESULTS];
   logic [1:0]             res_n;
   logic [OFFSET_BITS-1:0] off_next;
   logic [OFFSET_BITS-1:0] len_flush;
   logic [OFFSET_BITS-1:0] len_last;
   logic [7:0]             b;
   logic                   cont_ident;
   logic                   cont_int;
   logic                   is_nul;

   logic out_load;
   logic req_take;

   // Handshake: move a result into the output register when it is free or being taken.
   assign out_load = (grp_cnt_ff != 2'd0) && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !reset &&
                          ((grp_cnt_ff == 2'd0) || ((grp_cnt_ff == 2'd1) && out_load));
   assign req_take = req_bus.valid && req_bus.ready;

   assign b          = req_bus.in_byte;
   assign is_nul     = (b == 8'h00);
   assign cont_ident = (mode_ff == MODE_IDENT) && is_alpha(b);
   assign cont_int   = (mode_ff == MODE_INT) && is_digit(b);
   assign off_next   = offset_ff + OFFSET_BITS'(1);
   assign len_flush  = offset_ff - start_ff;

   // Scan one byte: next state and the list of results it causes.
   always_comb begin
      mode_in   = mode_ff;
      kp_in     = kp_ff;
      start_in  = start_ff;
      offset_in = offset_ff;
      res_n     = 2'd0;
      for (int k = 0; k < MAX_RESULTS; k++) begin
         res_c[k] = '0;
      end

      if (cont_ident) begin
         kp_in = kp_advance(kp_ff, b);
      end else if (!cont_int) begin
         // The byte ends any pending token.
         if (mode_ff != MODE_IDLE) begin
            res_c[res_n].token_kind   = flush_kind(mode_ff, kp_ff);
            res_c[res_n].start_offset = 16'(start_ff);
            res_c[res_n].token_length = 16'(len_flush);
            res_n   = res_n + 2'd1;
            mode_in = MODE_IDLE;
            kp_in   = KP_NONE;
         end
         if (is_nul) begin
            res_c[res_n].token_kind   = KIND_EOF;
            res_c[res_n].start_offset = 16'(offset_ff);
            res_n = res_n + 2'd1;
         end else if (is_blank(b)) begin
            mode_in = MODE_IDLE;
         end else if (is_alpha(b)) begin
            mode_in  = MODE_IDENT;
            start_in = offset_ff;
            kp_in    = kp_first(b);
         end else if (is_digit(b)) begin
            mode_in  = MODE_INT;
            start_in = offset_ff;
            kp_in    = KP_NONE;
         end else begin
            res_c[res_n].token_kind   = op_kind(b);
            res_c[res_n].start_offset = 16'(offset_ff);
            res_c[res_n].token_length = 16'd1;
            res_c[res_n].char_value   = b;
            res_n = res_n + 2'd1;
         end
      end

      // The end flag flushes what is pending, including this byte.
      len_last = off_next - start_in;
      if (!is_nul) begin
         offset_in = off_next;
         if (req_bus.end_of_text) begin
            if (mode_in != MODE_IDLE) begin
               res_c[res_n].token_kind   = flush_kind(mode_in, kp_in);
               res_c[res_n].start_offset = 16'(start_in);
               res_c[res_n].token_length = 16'(len_last);
               res_n = res_n + 2'd1;
            end
            res_c[res_n].token_kind   = KIND_EOF;
            res_c[res_n].start_offset = 16'(off_next);
            res_n = res_n + 2'd1;
         end
      end

      // End of file returns the scanner to its reset state.
      if (is_nul || req_bus.end_of_text) begin
         mode_in   = MODE_IDLE;
         kp_in     = KP_NONE;
         start_in  = '0;
         offset_in = '0;
      end

      if (res_n != 2'd0) begin
         res_c[2'(res_n - 2'd1)].last_of_run = 1'b1;
      end
   end

   // Scanner state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         kp_ff     <= KP_NONE;
         start_ff  <= '0;
         offset_ff <= '0;
      end else if (req_take) begin
         mode_ff   <= mode_in;
         kp_ff     <= kp_in;
         start_ff  <= start_in;
         offset_ff <= offset_in;
      end
   end

   // Result group: filled on a byte transfer, drained into the output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         grp_cnt_ff <= 2'd0;
         grp_idx_ff <= 2'd0;
      end else if (req_take) begin
         grp_cnt_ff <= res_n;
         grp_idx_ff <= 2'd0;
      end else if (out_load) begin
         grp_cnt_ff <= grp_cnt_ff - 2'd1;
         grp_idx_ff <= grp_idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         for (int k = 0; k < MAX_RESULTS; k++) begin
            grp_ff[k] <= res_c[k];
         end
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_ff <= grp_ff[grp_idx_ff];
      end
   end

   assign rsp_bus.valid        = out_valid_ff;
   assign rsp_bus.token_kind   = out_ff.token_kind;
   assign rsp_bus.start_offset = out_ff.start_offset;
   assign rsp_bus.token_length = out_ff.token_length;
   assign rsp_bus.char_value   = out_ff.char_value;
   assign rsp_bus.last_of_run  = out_ff.last_of_run;

endmodule
